// File: rtl/column_center_and_scale_top_macros.svh
// ----------------------------------------------------------------------------
// Column center and scale: assertion macros
// Concurrent check wrappers, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef COLUMN_CENTER_AND_SCALE_TOP_MACROS_SVH
`define COLUMN_CENTER_AND_SCALE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define CCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define CCS_ASSERT(lbl, prop, msg)
`define CCS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared constants, types and the sqrt(k) lookup for column center and scale.
// ----------------------------------------------------------------------------
`default_nettype none
package ccs_pkg;

    localparam int MAX_ROWS = 64;
    localparam int ADDR_W   = $clog2(MAX_ROWS);
    localparam int CNT_W    = $clog2(MAX_ROWS + 1);
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 22;
    localparam int ACC_W    = 38;
    localparam int RAD_W    = 54;
    localparam int ROOT_W   = 27;
    localparam int DIV_NW   = 34;
    localparam int DIV_DW   = 22;
    localparam int SCALE_W  = 20;
    localparam int TAB_W    = 16;

    // configuration register indexes
    localparam logic CFG_SCALE_MODE = 1'b0;
    localparam logic CFG_MIN_SCALE  = 1'b1;

    // status of a multi-cycle arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } ccs_unit_stat_t;

    typedef logic [TAB_W-1:0] root_tab_t [MAX_ROWS];

    // sqrt(k) in unsigned Q4.12, rounded to nearest; built at elaboration
    function automatic root_tab_t root_tab_build();
        root_tab_t        tab;
        longint unsigned  v;
        longint unsigned  r;
        longint unsigned  b;
        longint unsigned  rem;
        for (int k = 0; k < MAX_ROWS; k++)
        begin
            v   = longint'(k) << 24;
            rem = v;
            r   = 0;
            b   = 64'd1 << 40;
            while (b != 0 && b > rem)
                b = b >> 2;
            while (b != 0)
            begin
                if (rem >= r + b)
                begin
                    rem = rem - (r + b);
                    r   = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            if (r * r + r < v)
                r = r + 1;
            tab[k] = r[TAB_W-1:0];
        end
        return tab;
    endfunction

    localparam root_tab_t ROOT_TAB = root_tab_build();

endpackage
`default_nettype wire

// File: rtl/ccs_ram.sv
// ----------------------------------------------------------------------------
// ccs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/ccs_div.sv
// ----------------------------------------------------------------------------
// ccs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ccs_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ccs_pkg::DIV_NW-1:0]  num,
    input  wire logic [ccs_pkg::DIV_DW-1:0]  den,
    output      logic [ccs_pkg::DIV_NW-1:0]  quo,
    output      ccs_pkg::ccs_unit_stat_t     stat
);
    import ccs_pkg::*;

    localparam int CW = $clog2(DIV_NW);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] den_reg, den_next;
    logic [DIV_DW:0]   rem_sh;
    logic [DIV_DW:0]   diff;
    logic              ge;

    // one shift-subtract step
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[DIV_NW-1]};
        diff   = rem_sh - {1'b0, den_reg};
        ge     = rem_sh >= {1'b0, den_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DIV_NW - 1);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
            quo_next = {quo_reg[DIV_NW-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

// File: rtl/ccs_sqrt.sv
// ----------------------------------------------------------------------------
// ccs_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ccs_sqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ccs_pkg::RAD_W-1:0]   rad,
    output      logic [ccs_pkg::ROOT_W-1:0]  root,
    output      ccs_pkg::ccs_unit_stat_t     stat
);
    import ccs_pkg::*;

    localparam int CW    = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 2;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              ge;

    // bring down two radicand bits and try root*4+1
    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial  = (REM_W+2)'({root_reg, 2'b01});
        diff   = rem_sh - trial;
        ge     = rem_sh >= trial;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(ROOT_W - 1);
            rad_next  = rad;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_next = {root_reg[ROOT_W-2:0], ge};
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

// File: rtl/column_center_and_scale_top.sv
// ----------------------------------------------------------------------------
// column_center_and_scale_top
// Buffers one column of Q8.8 samples, then emits centered, scaled Q4.12 rows.
// ----------------------------------------------------------------------------
// A sample that does not close the column is taken without a stall and busy stays
// low. The sample with last_row closes the column and raises busy until its
// last result has been strobed: the mean division, the sum-of-squares pass
// over the row RAM, the square root, a second division in z-score mode with
// more than one row, then one divider run per row. Results appear on
// result_valid for exactly one cycle each and must be taken then; there is no
// backpressure. Configuration writes are always ready and belong between
// columns.
`default_nettype none
`include "column_center_and_scale_top_macros.svh"
module column_center_and_scale_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output      logic                          busy,
    input  wire logic signed [15:0]            sample,
    input  wire logic                          last_row,
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic                          cfg_index,
    input  wire logic [ccs_pkg::SCALE_W-1:0]   cfg_data,
    output      logic                          result_valid,
    output      logic signed [15:0]            normalized,
    output      logic signed [15:0]            column_mean,
    output      logic [ccs_pkg::SCALE_W-1:0]   column_scale,
    output      logic                          scale_fallback,
    output      logic                          clipped,
    output      logic                          rows_dropped,
    output      logic                          last_out
);
    import ccs_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE       = 14'b00000000000001,
        S_MEAN_GO    = 14'b00000000000010,
        S_MEAN_WAIT  = 14'b00000000000100,
        S_SQ         = 14'b00000000001000,
        S_SQ_DRAIN   = 14'b00000000010000,
        S_ROOT_GO    = 14'b00000000100000,
        S_ROOT_WAIT  = 14'b00000001000000,
        S_SCALE_GO   = 14'b00000010000000,
        S_SCALE_WAIT = 14'b00000100000000,
        S_FIX        = 14'b00001000000000,
        S_NRD        = 14'b00010000000000,
        S_NLD        = 14'b00100000000000,
        S_NGO        = 14'b01000000000000,
        S_NWAIT      = 14'b10000000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                ovf_reg, ovf_next;
    logic                mode_reg, mode_next;
    logic [SCALE_W-1:0]  min_reg, min_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                v1_reg, v1_next;
    logic                v2_reg, v2_next;
    logic                v3_reg, v3_next;
    logic                res_v_reg, res_v_next;

    logic [15:0]         mean_reg, mean_next;
    logic [15:0]         absd_reg, absd_next;
    logic                neg_reg, neg_next;
    logic [31:0]         prod_reg, prod_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [SCALE_W-1:0]  raw_reg, raw_next;
    logic [SCALE_W-1:0]  scale_reg, scale_next;
    logic                fb_reg, fb_next;
    logic [15:0]         norm_reg, norm_next;
    logic                clip_reg, clip_next;
    logic                drop_reg, drop_next;
    logic                lastq_reg, lastq_next;

    // row RAM
    logic                ram_we;
    logic [15:0]         ram_rdata;

    // arithmetic units
    logic                div_start;
    logic [DIV_NW-1:0]   div_num;
    logic [DIV_DW-1:0]   div_den;
    logic [DIV_NW-1:0]   div_quo;
    ccs_unit_stat_t      div_stat;
    logic                sqrt_start;
    logic [ROOT_W-1:0]   sqrt_root;
    ccs_unit_stat_t      sqrt_stat;

    logic                accept;
    logic                full;
    logic [SUM_W-1:0]    mag;
    logic signed [17:0]  dval;
    logic [17:0]         dabs;
    logic [CNT_W-1:0]    n_m1;
    logic [TAB_W-1:0]    tab_t;
    logic                is_final;

    ccs_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_ROWS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (sample),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    ccs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .stat  (div_stat)
    );

    ccs_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   ({acc_reg, 16'd0}),
        .root  (sqrt_root),
        .stat  (sqrt_stat)
    );

    // shared datapath terms
    always_comb
    begin
        accept   = start && (state_reg == S_IDLE);
        full     = cnt_reg == CNT_W'(MAX_ROWS);
        ram_we   = accept && !full;
        mag      = sum_reg[SUM_W-1] ? (SUM_W'(0) - sum_reg) : sum_reg;
        dval     = 18'(signed'(ram_rdata)) - 18'(signed'(mean_reg));
        dabs     = dval[17] ? (18'd0 - dval) : dval;
        n_m1     = cnt_reg - CNT_W'(1);
        tab_t    = ROOT_TAB[n_m1[ADDR_W-1:0]];
        is_final = idx_reg == n_m1;
    end

    // divider and root operand select
    always_comb
    begin
        div_start  = 1'b0;
        sqrt_start = (state_reg == S_ROOT_GO);
        div_num    = '0;
        div_den    = '0;
        case (state_reg)
            S_MEAN_GO:
            begin
                div_start = 1'b1;
                div_num   = DIV_NW'({mag, 1'b0}) + DIV_NW'(cnt_reg);
                div_den   = DIV_DW'({cnt_reg, 1'b0});
            end
            S_SCALE_GO:
            begin
                div_start = 1'b1;
                div_num   = DIV_NW'({sqrt_root, 5'd0}) + DIV_NW'(tab_t);
                div_den   = DIV_DW'({tab_t, 1'b0});
            end
            S_NGO:
            begin
                div_start = 1'b1;
                div_num   = DIV_NW'({absd_reg, 13'd0}) + DIV_NW'(scale_reg);
                div_den   = DIV_DW'({scale_reg, 1'b0});
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        mode_next  = mode_reg;
        min_next   = min_reg;
        idx_next   = idx_reg;
        res_v_next = 1'b0;
        mean_next  = mean_reg;
        raw_next   = raw_reg;
        scale_next = scale_reg;
        fb_next    = fb_reg;
        absd_next  = absd_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        norm_next  = norm_reg;
        clip_next  = clip_reg;
        drop_next  = drop_reg;
        lastq_next = lastq_reg;

        // squaring pipeline: RAM read, |d|, product, accumulate
        v1_next   = (state_reg == S_SQ);
        v2_next   = v1_reg;
        v3_next   = v2_reg;
        prod_next = 32'(absd_reg) * 32'(absd_reg);
        if (v1_reg)
            absd_next = dabs[15:0];
        if (v3_reg)
            acc_next = acc_reg + ACC_W'(prod_reg);

        // configuration transfer
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SCALE_MODE: mode_next = cfg_data[0];
                CFG_MIN_SCALE:  min_next  = cfg_data;
                default:        mode_next = mode_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        sum_next = sum_reg + SUM_W'(signed'(sample));
                    end
                    if (last_row)
                        state_next = S_MEAN_GO;
                end
            end
            S_MEAN_GO:
            begin
                state_next = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
            begin
                if (div_stat.done)
                begin
                    mean_next  = sum_reg[SUM_W-1] ? (16'd0 - div_quo[15:0]) : div_quo[15:0];
                    acc_next   = '0;
                    idx_next   = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                idx_next = idx_reg + CNT_W'(1);
                if (is_final)
                    state_next = S_SQ_DRAIN;
            end
            S_SQ_DRAIN:
            begin
                if (!v1_reg && !v2_reg && !v3_reg)
                    state_next = S_ROOT_GO;
            end
            S_ROOT_GO:
            begin
                state_next = S_ROOT_WAIT;
            end
            S_ROOT_WAIT:
            begin
                if (sqrt_stat.done)
                begin
                    if (mode_reg && (cnt_reg > CNT_W'(1)))
                    begin
                        state_next = S_SCALE_GO;
                    end
                    else
                    begin
                        raw_next   = SCALE_W'((ROOT_W+1)'(sqrt_root) + (ROOT_W+1)'(128) >> 8);
                        state_next = S_FIX;
                    end
                end
            end
            S_SCALE_GO:
            begin
                state_next = S_SCALE_WAIT;
            end
            S_SCALE_WAIT:
            begin
                if (div_stat.done)
                begin
                    raw_next   = (div_quo > DIV_NW'(20'hFFFFF)) ? 20'hFFFFF
                                                               : div_quo[SCALE_W-1:0];
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                // zero or too-small scale falls back to 1.0
                if (raw_reg == '0 || raw_reg < min_reg)
                begin
                    scale_next = SCALE_W'(256);
                    fb_next    = 1'b1;
                end
                else
                begin
                    scale_next = raw_reg;
                    fb_next    = 1'b0;
                end
                idx_next   = '0;
                state_next = S_NRD;
            end
            S_NRD:
            begin
                state_next = S_NLD;
            end
            S_NLD:
            begin
                absd_next  = dabs[15:0];
                neg_next   = dval[17];
                state_next = S_NGO;
            end
            S_NGO:
            begin
                state_next = S_NWAIT;
            end
            S_NWAIT:
            begin
                if (div_stat.done)
                begin
                    // round done by the divider; saturate to Q4.12
                    if (neg_reg)
                    begin
                        clip_next = div_quo > DIV_NW'(32768);
                        norm_next = clip_next ? 16'h8000 : (16'd0 - div_quo[15:0]);
                    end
                    else
                    begin
                        clip_next = div_quo > DIV_NW'(32767);
                        norm_next = clip_next ? 16'h7FFF : div_quo[15:0];
                    end
                    res_v_next = 1'b1;
                    drop_next  = ovf_reg;
                    lastq_next = is_final;
                    idx_next   = idx_reg + CNT_W'(1);
                    if (is_final)
                    begin
                        cnt_next   = '0;
                        sum_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_NRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            mode_reg  <= 1'b0;
            min_reg   <= SCALE_W'(1);
            idx_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_next;
            mode_reg  <= mode_next;
            min_reg   <= min_next;
            idx_reg   <= idx_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            v3_reg    <= v3_next;
            res_v_reg <= res_v_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mean_reg  <= mean_next;
        absd_reg  <= absd_next;
        neg_reg   <= neg_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        raw_reg   <= raw_next;
        scale_reg <= scale_next;
        fb_reg    <= fb_next;
        norm_reg  <= norm_next;
        clip_reg  <= clip_next;
        drop_reg  <= drop_next;
        lastq_reg <= lastq_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign cfg_ready      = 1'b1;
    assign result_valid   = res_v_reg;
    assign normalized     = signed'(norm_reg);
    assign column_mean    = signed'(mean_reg);
    assign column_scale   = scale_reg;
    assign scale_fallback = fb_reg;
    assign clipped        = clip_reg;
    assign rows_dropped   = drop_reg;
    assign last_out       = lastq_reg;

    // checks
    `CCS_ASSERT(a_res_busy, res_v_reg && !lastq_reg |-> busy, "result before column end while idle")
    `CCS_ASSERT_NEXT(a_close_busy, accept && last_row, busy, "closing sample did not start work")
    `CCS_ASSERT(a_div_idle, div_start |-> !div_stat.busy, "divider restarted while running")
    `CCS_ASSERT(a_scale_nz, res_v_reg |-> scale_reg != '0, "zero scale on result")

endmodule
`default_nettype wire
